>>> rtl/core/tboc_pkg.sv
package tboc_pkg;

   localparam logic OP_DECODE = 1'b0;
   localparam logic OP_ENCODE = 1'b1;

   localparam logic [15:0] UPPER_MASK   = 16'hF800;
   localparam logic [15:0] UPPER_MATCH  = 16'hF000;
   localparam logic [15:0] BLX_MASK     = 16'hD001;
   localparam logic [15:0] BLX_MATCH    = 16'hC000;
   localparam logic [15:0] BL_MASK      = 16'hD000;
   localparam logic [15:0] BL_MATCH     = 16'hD000;
   localparam logic [15:0] UPPER_PREFIX = 16'hF000;
   localparam logic [15:0] LOWER_PREFIX = 16'hD000;

   localparam int unsigned DIFF_WIDTH = 34;

   typedef struct packed {
      logic        valid_res;
      logic [31:0] decoded_target;
      logic [15:0] enc_upper;
      logic [15:0] enc_lower;
   } result_type;

   function automatic result_type decode_fn(input logic [15:0] up, input logic [15:0] lo,
                                            input logic xchg, input logic [31:0] addr);
      result_type  res;
      logic        ok;
      logic        s;
      logic        i1;
      logic        i2;
      logic [31:0] disp;
      logic [29:0] base_word;
      logic [31:0] base;
      res = '0;
      ok = ((up & UPPER_MASK) == UPPER_MATCH) &&
           (xchg ? ((lo & BLX_MASK) == BLX_MATCH) : ((lo & BL_MASK) == BL_MATCH));
      s = up[10];
      i1 = ~(lo[13] ^ s);
      i2 = ~(lo[11] ^ s);
      disp = {{8{s}}, i1, i2, up[9:0], lo[10:0], 1'b0};
      base_word = addr[31:2] + 30'd1;
      base = {base_word, xchg ? 2'b00 : addr[1:0]};
      if (ok) begin
         res.valid_res = 1'b1;
         res.decoded_target = base + disp;
      end
      return res;
   endfunction

   function automatic result_type encode_fn(input logic [31:0] addr, input logic [31:0] target);
      result_type            res;
      logic [DIFF_WIDTH-1:0] d;
      logic                  in_range;
      logic                  s;
      logic                  j1;
      logic                  j2;
      res = '0;
      d = {2'b00, target} - {2'b00, addr} - DIFF_WIDTH'(4);
      // A 25-bit signed value has all bits above bit 24 equal to its sign bit.
      in_range = (d[DIFF_WIDTH-1:24] == '0) || (d[DIFF_WIDTH-1:24] == '1);
      s = d[24];
      j1 = ~(d[23] ^ s);
      j2 = ~(d[22] ^ s);
      if (in_range && !d[0]) begin
         res.valid_res = 1'b1;
         res.enc_upper = UPPER_PREFIX | {5'b0, s, d[21:12]};
         res.enc_lower = LOWER_PREFIX | {2'b0, j1, 1'b0, j2, d[11:1]};
      end
      return res;
   endfunction

endpackage

>>> rtl/core/thumb_branch_offset_codec_top.sv
// Thumb-2 BL/BLX branch offset codec.
// Requests arrive on the req_ channel under a valid/ready handshake. A decode
// transaction checks a halfword pair for the BL or BLX pattern and returns the
// branch target; an encode transaction turns an instruction address and a
// target address into a BL halfword pair, or flags the displacement as invalid.
// Every request yields exactly one response on the rsp_ channel.
// Path from an accepted request to its response being shown: the input
// register, the field logic and adders, then the response register. Throughput
// is one transaction per cycle while the receiver does not stall; the block
// holds up to two transactions in flight.
// When the receiver stalls, the response register holds its value and the
// input register fills; req_ready drops only when both are occupied.
// Reset empties both stages; no response is shown after reset until a new
// request has been accepted.
module thumb_branch_offset_codec_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [15:0] req_upper_half,
   input  logic [15:0] req_lower_half,
   input  logic        req_exchange,
   input  logic [31:0] req_instr_address,
   input  logic [31:0] req_target_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valid_res,
   output logic [31:0] rsp_decoded_target,
   output logic [15:0] rsp_enc_upper,
   output logic [15:0] rsp_enc_lower
);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic        op_ff;
   logic [15:0] upper_ff;
   logic [15:0] lower_ff;
   logic        exchange_ff;
   logic [31:0] instr_ff;
   logic [31:0] target_ff;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   tboc_pkg::result_type result_ff;
   tboc_pkg::result_type result_in;

   logic out_load;
   logic in_load;

   assign out_load  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || out_load;
   assign in_load   = req_valid && req_ready;

   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   always_comb begin
      if (op_ff == tboc_pkg::OP_ENCODE) begin
         result_in = tboc_pkg::encode_fn(instr_ff, target_ff);
      end else begin
         result_in = tboc_pkg::decode_fn(upper_ff, lower_ff, exchange_ff, instr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         op_ff       <= req_operation;
         upper_ff    <= req_upper_half;
         lower_ff    <= req_lower_half;
         exchange_ff <= req_exchange;
         instr_ff    <= req_instr_address;
         target_ff   <= req_target_address;
      end
      if (out_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_valid_res      = result_ff.valid_res;
   assign rsp_decoded_target = result_ff.decoded_target;
   assign rsp_enc_upper      = result_ff.enc_upper;
   assign rsp_enc_lower      = result_ff.enc_lower;

endmodule

>>> rtl/core/tboc_checker.sv
module tboc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_valid_res,
   input logic [31:0] rsp_decoded_target,
   input logic [15:0] rsp_enc_upper,
   input logic [15:0] rsp_enc_lower
);

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_valid_res) &&
      $stable(rsp_decoded_target) && $stable(rsp_enc_upper) && $stable(rsp_enc_lower))
      else $error("stalled response changed");

   // Nothing is shown right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response shown after reset");

   // With the response stage empty the block always takes a request.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request refused with empty response stage");

   // An invalid result carries all-zero fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
      rsp_decoded_target == 32'd0 && rsp_enc_upper == 16'd0 && rsp_enc_lower == 16'd0)
      else $error("invalid result with nonzero fields");

   // A nonzero encoded pair is a well-formed BL and comes without a target.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enc_upper != 16'd0 |->
      rsp_valid_res && rsp_enc_upper[15:11] == 5'b11110 && rsp_enc_lower[15:14] == 2'b11 &&
      rsp_enc_lower[12] && rsp_decoded_target == 32'd0)
      else $error("malformed encoded pair");

endmodule

bind thumb_branch_offset_codec_top tboc_checker u_tboc_checker (.*);

>>> test/tb_thumb_branch_offset_codec_top.sv
`timescale 1ns / 100ps

module tb_thumb_branch_offset_codec_top;

   localparam int          CYCLE_LIMIT = 400000;
   localparam longint      DISP_LIMIT  = 64'sd16777216;
   localparam logic [31:0] SIGN_FILL   = 32'hFF000000;

   typedef struct packed {
      logic        valid_res;
      logic [31:0] target;
      logic [15:0] upper;
      logic [15:0] lower;
   } branch_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = tboc_pkg::OP_DECODE;
   logic [15:0] req_upper_half = '0;
   logic [15:0] req_lower_half = '0;
   logic        req_exchange = 1'b0;
   logic [31:0] req_instr_address = '0;
   logic [31:0] req_target_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_valid_res;
   logic [31:0] rsp_decoded_target;
   logic [15:0] rsp_enc_upper;
   logic [15:0] rsp_enc_lower;

   branch_result_type expected_results[$];
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 8;
   int recv_stall_pct = 57;
   int holdoff_left = 0;
   int num_decodes = 0;
   int num_encodes = 0;
   int num_valid = 0;
   int num_responses = 0;

   thumb_branch_offset_codec_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_upper_half     (req_upper_half),
      .req_lower_half     (req_lower_half),
      .req_exchange       (req_exchange),
      .req_instr_address  (req_instr_address),
      .req_target_address (req_target_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_valid_res      (rsp_valid_res),
      .rsp_decoded_target (rsp_decoded_target),
      .rsp_enc_upper      (rsp_enc_upper),
      .rsp_enc_lower      (rsp_enc_lower)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, expected_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic branch_result_type predict_branch(input logic op, input logic [15:0] up,
                                                        input logic [15:0] lo, input logic xchg,
                                                        input logic [31:0] addr,
                                                        input logic [31:0] tgt);
      branch_result_type res;
      logic              matched;
      logic              s;
      logic [31:0]       disp;
      logic [31:0]       base;
      longint            diff;
      logic [31:0]       imm;
      res = '0;
      if (op == tboc_pkg::OP_DECODE) begin
         matched = ((up & tboc_pkg::UPPER_MASK) == tboc_pkg::UPPER_MATCH) &&
                   (xchg ? ((lo & tboc_pkg::BLX_MASK) == tboc_pkg::BLX_MATCH)
                         : ((lo & tboc_pkg::BL_MASK) == tboc_pkg::BL_MATCH));
         if (matched) begin
            s = up[10];
            disp = (s ? SIGN_FILL : 32'h0);
            disp[23] = 1'b1 ^ lo[13] ^ s;
            disp[22] = 1'b1 ^ lo[11] ^ s;
            disp[21:12] = up[9:0];
            disp[11:1] = lo[10:0];
            disp[0] = 1'b0;
            base = addr + 32'd4;
            if (xchg) begin
               base[1:0] = 2'b00;
            end
            res.valid_res = 1'b1;
            res.target = base + disp;
         end
      end else begin
         diff = longint'(tgt) - longint'(addr) - 64'sd4;
         if (diff[0] == 1'b0 && diff >= -DISP_LIMIT && diff < DISP_LIMIT) begin
            imm = diff[31:0];
            s = imm[24];
            res.valid_res = 1'b1;
            res.upper = tboc_pkg::UPPER_PREFIX | {5'b0, s, imm[21:12]};
            res.lower = tboc_pkg::LOWER_PREFIX | {2'b0, 1'b1 ^ imm[23] ^ s, 1'b0,
                                                  1'b1 ^ imm[22] ^ s, imm[11:1]};
         end
      end
      return res;
   endfunction

   task automatic send_request(input logic op, input logic [15:0] up, input logic [15:0] lo,
                               input logic xchg, input logic [31:0] addr,
                               input logic [31:0] tgt);
      branch_result_type res;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_operation = op;
      req_upper_half = up;
      req_lower_half = lo;
      req_exchange = xchg;
      req_instr_address = addr;
      req_target_address = tgt;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      res = predict_branch(op, up, lo, xchg, addr, tgt);
      expected_results.push_back(res);
      if (op == tboc_pkg::OP_DECODE) num_decodes++;
      else num_encodes++;
      if (res.valid_res) num_valid++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_ready = 1'b0;
         holdoff_left = holdoff_left - 1;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic report_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      branch_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         num_responses++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response transaction, expected none, actual %b %h %h %h",
                     $time, rsp_valid_res, rsp_decoded_target, rsp_enc_upper, rsp_enc_lower);
            error_count++;
         end else begin
            exp_res = expected_results.pop_front();
            report_field("valid_res", 32'(exp_res.valid_res), 32'(rsp_valid_res));
            report_field("decoded_target", exp_res.target, rsp_decoded_target);
            report_field("enc_upper", 32'(exp_res.upper), 32'(rsp_enc_upper));
            report_field("enc_lower", 32'(exp_res.lower), 32'(rsp_enc_lower));
         end
      end
   end

   task automatic test_decode_directed();
      send_request(tboc_pkg::OP_DECODE, 16'hF000, 16'hF800, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(tboc_pkg::OP_DECODE, 16'hF3FF, 16'hD7FF, 1'b0, 32'hFFFF_FFFC, 32'h0);
      send_request(tboc_pkg::OP_DECODE, 16'hF400, 16'hD000, 1'b0, 32'h0000_0000, 32'h0);
      send_request(tboc_pkg::OP_DECODE, 16'hF7FF, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 32'h0);
      send_request(tboc_pkg::OP_DECODE, 16'hF000, 16'hC000, 1'b1, 32'h0000_0002, 32'h0);
      send_request(tboc_pkg::OP_DECODE, 16'hF7FF, 16'hEFFE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(tboc_pkg::OP_DECODE, 16'hF000, 16'hC001, 1'b1, 32'h1234_5678, 32'h0);
      send_request(tboc_pkg::OP_DECODE, 16'hF000, 16'hE800, 1'b1, 32'h1234_5678, 32'h0);
      send_request(tboc_pkg::OP_DECODE, 16'hF000, 16'hC000, 1'b0, 32'h1234_5678, 32'h0);
      send_request(tboc_pkg::OP_DECODE, 16'hE800, 16'hF800, 1'b0, 32'h1234_5678, 32'h0);
      send_request(tboc_pkg::OP_DECODE, 16'hFFFF, 16'hFFFF, 1'b0, 32'h1234_5678, 32'h0);
      send_request(tboc_pkg::OP_DECODE, 16'h0000, 16'h0000, 1'b1, 32'h0000_0000, 32'h0);
   endtask

   task automatic test_encode_directed();
      send_request(tboc_pkg::OP_ENCODE, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0000_1000, 32'h0000_1004);
      send_request(tboc_pkg::OP_ENCODE, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000, 32'h0100_0002);
      send_request(tboc_pkg::OP_ENCODE, 16'h0000, 16'h0000, 1'b0, 32'h0100_0000, 32'h0000_0004);
      send_request(tboc_pkg::OP_ENCODE, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000, 32'h0100_0004);
      send_request(tboc_pkg::OP_ENCODE, 16'h0000, 16'h0000, 1'b0, 32'h0100_0002, 32'h0000_0004);
      send_request(tboc_pkg::OP_ENCODE, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000, 32'h0000_0007);
      send_request(tboc_pkg::OP_ENCODE, 16'h0000, 16'h0000, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
      send_request(tboc_pkg::OP_ENCODE, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000, 32'hFFFF_FFFE);
      send_request(tboc_pkg::OP_ENCODE, 16'h0000, 16'h0000, 1'b0, 32'hFFFF_FFF0, 32'hFFFF_FFF4);
      send_request(tboc_pkg::OP_ENCODE, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000, 32'h0000_0002);
   endtask

   task automatic send_random_item();
      int          kind;
      int          disp;
      logic        xchg;
      logic [15:0] up;
      logic [15:0] lo;
      logic [31:0] addr;
      logic [31:0] tgt;
      kind = $urandom_range(0, 99);
      xchg = 1'($urandom_range(0, 1));
      up = 16'($urandom);
      lo = 16'($urandom);
      addr = $urandom;
      tgt = $urandom;
      if ($urandom_range(0, 19) == 0) begin
         addr = ($urandom_range(0, 1) == 1) ? (32'hFFFF_FFFF - ($urandom & 32'hFF))
                                            : ($urandom & 32'hFF);
      end
      if (kind < 40) begin
         up = tboc_pkg::UPPER_MATCH | (up & ~tboc_pkg::UPPER_MASK);
         lo = xchg ? (tboc_pkg::BLX_MATCH | (lo & ~tboc_pkg::BLX_MASK))
                   : (tboc_pkg::BL_MATCH | (lo & ~tboc_pkg::BL_MASK));
         send_request(tboc_pkg::OP_DECODE, up, lo, xchg, addr, tgt);
      end else if (kind < 50) begin
         if ($urandom_range(0, 1) == 1) begin
            up = tboc_pkg::UPPER_MATCH | (up & ~tboc_pkg::UPPER_MASK);
         end
         send_request(tboc_pkg::OP_DECODE, up, lo, xchg, addr, tgt);
      end else if (kind < 85) begin
         case ($urandom_range(0, 9))
            0: disp = 32'sh00FF_FFFE;
            1: disp = -32'sh0100_0000;
            2: disp = 32'sh0100_0000;
            3: disp = -32'sh0100_0002;
            4: disp = $urandom_range(0, 1023) - 512;
            default: disp = int'($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
         endcase
         disp = disp & ~32'sd1;
         if ($urandom_range(0, 9) == 0) disp = disp | 32'sd1;
         tgt = addr + 32'd4 + 32'(disp);
         send_request(tboc_pkg::OP_ENCODE, up, lo, xchg, addr, tgt);
      end else begin
         send_request(tboc_pkg::OP_ENCODE, up, lo, xchg, addr, tgt);
      end
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_random_item();
   endtask

   task automatic test_receiver_holdoff();
      int saved_idle;
      saved_idle = send_idle_pct;
      send_idle_pct = 0;
      holdoff_left = 80;
      repeat (30) send_random_item();
      send_idle_pct = saved_idle;
   endtask

   task automatic test_sender_pause();
      wait_for_drain();
      repeat (3) send_random_item();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_decode_directed();
      test_encode_directed();
      test_random_traffic(500, 8, 57);
      test_receiver_holdoff();
      test_random_traffic(500, 57, 8);
      test_sender_pause();
      test_random_traffic(500, 0, 0);

      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("Ran %0d decode and %0d encode transactions, %0d of them valid, %0d responses.",
               num_decodes, num_encodes, num_valid, num_responses);
      $display({"Traffic included directed corners, random idling on both sides, a long ",
                "receiver hold-off and a full drain pause."});
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
